### sv/tct_pkg.sv
// Package of shared types, constants and codes for the TCP connection tracker.
`timescale 1ns / 1ps

package tct_pkg;

  // Number of connection records; must be a power of two.
  localparam int unsigned CONN_SLOTS = 1024;
  localparam int unsigned SLOT_W     = $clog2(CONN_SLOTS);
  localparam int unsigned CSLOT_W    = 10;
  localparam int unsigned SLOTX_W    = (SLOT_W > CSLOT_W) ? SLOT_W : CSLOT_W;

  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 112;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SYN_SENT_TIMEOUT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYN_RECV_TIMEOUT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESTABLISHED_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_CLOSED_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED_TIMEOUT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRACKED_PORT        = 3'd5;

  // Connection states as stored in the record.
  localparam logic [2:0] CS_NEW         = 3'd0;
  localparam logic [2:0] CS_SYN_SENT    = 3'd1;
  localparam logic [2:0] CS_SYN_RECV    = 3'd2;
  localparam logic [2:0] CS_ESTABLISHED = 3'd3;
  localparam logic [2:0] CS_HALF_CLOSED = 3'd4;
  localparam logic [2:0] CS_CLOSED      = 3'd5;

  // Bit positions in the flag byte.
  localparam int unsigned FL_FIN = 0;
  localparam int unsigned FL_SYN = 1;
  localparam int unsigned FL_RST = 2;
  localparam int unsigned FL_ACK = 4;

  // Bit positions in the mark byte.
  localparam int unsigned MK_FIN_FWD    = 0;
  localparam int unsigned MK_KNOWN_FWD  = 2;
  localparam int unsigned MK_CLIENT_FWD = 4;
  localparam int unsigned MK_ASSURED    = 6;
  localparam int unsigned MK_TRACKED    = 7;

  localparam logic [15:0] MIN_HDR_BYTES = 16'd20;

  // Segment header as packed on the input bus, last field lowest.
  typedef struct packed {
    logic [15:0]        dst_port;
    logic [15:0]        src_port;
    logic [31:0]        ack_num;
    logic [31:0]        seq_num;
    logic [7:0]         tcp_flags;
    logic [15:0]        segment_len;
    logic [3:0]         data_offset;
    logic               direction;
    logic               new_entry;
    logic [CSLOT_W-1:0] conn_slot;
  } seg_hdr_t;

  // Result as packed on the output bus, last field lowest.
  typedef struct packed {
    logic [6:0]  pad;
    logic        seq_assured;
    logic [31:0] rev_start_seq;
    logic [31:0] fwd_start_seq;
    logic        rev_known;
    logic        fwd_known;
    logic [1:0]  learned_mask;
    logic [15:0] payload_len;
    logic [15:0] timeout_secs;
    logic [2:0]  conn_state;
    logic        status;
  } seg_result_t;

  // One connection record in the table memory.
  typedef struct packed {
    logic [2:0]  state;
    logic [7:0]  mark;
    logic [31:0] fwd_seq;
    logic [31:0] rev_seq;
  } conn_rec_t;

endpackage

### sv/tct_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module tct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/tcp_connection_tracker.sv
// Top level of the TCP connection tracker: header check, record update and result output.
`timescale 1ns / 1ps

// Each input transfer carries the parsed header of one TCP segment together with the slot
// of its connection record, its direction and a new-connection mark. The block checks the
// header, reads the record from a single-port-read table memory, works out the new state,
// FIN marks and learned start sequences, writes the record back and returns one result
// transfer per segment. A segment passes through the registered memory read in IDLE and
// the update and write-back in CALC, which waits while the output register is still full.
// No new header is taken until CALC is done, as set by the read-modify-write of the table.
// A result waits in an output register while the next header is already being taken. The
// write-back lands before the next read is issued, so back-to-back headers to the same slot
// need no forwarding. The table is not cleared at reset: a slot must be opened with the
// new-entry mark before it is used. The user must write configuration only while the
// block is idle; the block does not enforce it. conn_slot wraps modulo the record count.
module tcp_connection_tracker (
  input  logic                            clk,
  input  logic                            rst,
  // Input: conn_slot, new_entry, direction, data_offset, segment_len, tcp_flags,
  // seq_num, ack_num, src_port, dst_port (lowest bit first).
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tct_pkg::IN_DATA_W-1:0]   s_tdata,
  // Output: status, conn_state, timeout_secs, payload_len, learned_mask, fwd_known,
  // rev_known, fwd_start_seq, rev_start_seq, seq_assured, zero padding (lowest bit first).
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tct_pkg::OUT_DATA_W-1:0]  m_tdata,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tct_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import tct_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CALC = 2'b10
  } fsm_state_t;

  fsm_state_t state, state_next;

  // Configuration registers.
  logic [15:0] syn_sent_timeout, syn_recv_timeout, established_timeout;
  logic [15:0] half_closed_timeout, closed_timeout, tracked_port;

  seg_hdr_t    in_hdr, hdr;
  seg_result_t res, out_res;
  conn_rec_t   rd_rec, wr_rec;

  logic [SLOTX_W-1:0] in_slot_x, hdr_slot_x;
  logic [SLOT_W-1:0]  in_slot, hdr_slot;

  logic in_xfer, out_xfer, cfg_xfer;
  logic finish;
  logic wr_en;
  logic valid_hdr;

  assign in_hdr    = seg_hdr_t'(s_tdata);
  assign in_xfer   = s_tvalid && s_tready;
  assign out_xfer  = m_tvalid && m_tready;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // The slot count is a power of two, so wrapping is a matter of keeping the low bits.
  assign in_slot_x  = SLOTX_W'(in_hdr.conn_slot);
  assign in_slot    = in_slot_x[SLOT_W-1:0];
  assign hdr_slot_x = SLOTX_W'(hdr.conn_slot);
  assign hdr_slot   = hdr_slot_x[SLOT_W-1:0];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      syn_sent_timeout    <= 16'd180;
      syn_recv_timeout    <= 16'd60;
      established_timeout <= 16'd7200;
      half_closed_timeout <= 16'd120;
      closed_timeout      <= 16'd30;
      tracked_port        <= 16'd80;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        REG_SYN_SENT_TIMEOUT:    syn_sent_timeout    <= cfg_data;
        REG_SYN_RECV_TIMEOUT:    syn_recv_timeout    <= cfg_data;
        REG_ESTABLISHED_TIMEOUT: established_timeout <= cfg_data;
        REG_HALF_CLOSED_TIMEOUT: half_closed_timeout <= cfg_data;
        REG_CLOSED_TIMEOUT:      closed_timeout      <= cfg_data;
        REG_TRACKED_PORT:        tracked_port        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control: a header is taken in IDLE, its record read arrives in CALC, and CALC
  // finishes once the output register is free.
  assign s_tready = (state == S_IDLE);
  assign finish   = (state == S_CALC) && (!m_tvalid || m_tready);
  assign wr_en    = finish && valid_hdr;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) state_next = S_CALC;
      end
      S_CALC: begin
        if (finish) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hdr <= in_hdr;
    end
  end

  tct_ram #(
    .WIDTH ($bits(conn_rec_t)),
    .DEPTH (CONN_SLOTS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (hdr_slot),
    .wdata (wr_rec),
    .re    (in_xfer),
    .raddr (in_slot),
    .rdata (rd_rec)
  );

  // Record update for the header held in hdr.
  always_comb begin
    logic [5:0]  hlen;
    logic [15:0] plen;
    logic        syn, fin, rst_fl, ack;
    logic        dir, rdir;
    logic [2:0]  kd, kr, cd, cr, fd;
    logic [2:0]  st;
    logic [7:0]  mark;
    logic [31:0] sq [2];
    logic [31:0] s1;
    logic [1:0]  learned;
    logic [15:0] tmo;

    hlen    = {hdr.data_offset, 2'b00};
    plen    = hdr.segment_len - 16'(hlen);
    syn     = hdr.tcp_flags[FL_SYN];
    fin     = hdr.tcp_flags[FL_FIN];
    rst_fl  = hdr.tcp_flags[FL_RST];
    ack     = hdr.tcp_flags[FL_ACK];
    dir     = hdr.direction;
    rdir    = ~hdr.direction;
    // Mark bit positions that depend on the direction of the segment.
    kd      = 3'(MK_KNOWN_FWD) + {2'b00, dir};
    kr      = 3'(MK_KNOWN_FWD) + {2'b00, rdir};
    cd      = 3'(MK_CLIENT_FWD) + {2'b00, dir};
    cr      = 3'(MK_CLIENT_FWD) + {2'b00, rdir};
    fd      = 3'(MK_FIN_FWD) + {2'b00, dir};
    learned = 2'b00;
    s1      = hdr.seq_num + 32'd1;

    valid_hdr = (hdr.segment_len >= MIN_HDR_BYTES) && (16'(hlen) >= MIN_HDR_BYTES) &&
                (16'(hlen) <= hdr.segment_len) &&
                !(syn && ((plen != 16'd0) || rst_fl || fin));

    if (rst_fl) plen = 16'd0;

    if (hdr.new_entry) begin
      st    = CS_NEW;
      mark  = 8'd0;
      mark[MK_TRACKED] = (hdr.src_port == tracked_port) || (hdr.dst_port == tracked_port);
      sq[0] = 32'd0;
      sq[1] = 32'd0;
    end else begin
      st    = rd_rec.state;
      mark  = rd_rec.mark;
      sq[0] = rd_rec.fwd_seq;
      sq[1] = rd_rec.rev_seq;
    end

    // Start-sequence learning on tracked connections.
    if (mark[MK_TRACKED]) begin
      if (syn) begin
        if (!(mark[kd] && (sq[dir] != s1))) begin
          sq[dir] = s1;
          mark[kd] = 1'b1;
          learned[dir] = 1'b1;
        end
        if (ack) begin
          if (!(mark[kr] && (sq[rdir] != hdr.ack_num))) begin
            sq[rdir] = hdr.ack_num;
            mark[kr] = 1'b1;
            learned[rdir] = 1'b1;
          end
          mark[cr] = 1'b1;
        end else begin
          mark[cd] = 1'b1;
        end
      end else if (!mark[MK_ASSURED] && ack && (sq[dir] == hdr.seq_num) &&
                   (plen == 16'd0) && mark[kd] && mark[cd]) begin
        sq[rdir] = hdr.ack_num;
        mark[kr] = 1'b1;
        mark[MK_ASSURED] = 1'b1;
        learned[rdir] = 1'b1;
      end
    end

    // State transition: SYN first, then FIN, then RST, else a plain segment.
    if (syn) begin
      if (ack) begin
        if (st <= CS_SYN_SENT) st = CS_SYN_RECV;
      end else if (st == CS_NEW) begin
        st = CS_SYN_SENT;
      end
    end else if (fin) begin
      mark[fd] = 1'b1;
      st = (mark[1:0] == 2'b11) ? CS_CLOSED : CS_HALF_CLOSED;
    end else if (rst_fl) begin
      st = CS_CLOSED;
    end else if (st < CS_ESTABLISHED) begin
      st = CS_ESTABLISHED;
    end

    case (st)
      CS_SYN_SENT:    tmo = syn_sent_timeout;
      CS_SYN_RECV:    tmo = syn_recv_timeout;
      CS_ESTABLISHED: tmo = established_timeout;
      CS_HALF_CLOSED: tmo = half_closed_timeout;
      CS_CLOSED:      tmo = closed_timeout;
      default:        tmo = 16'd0;
    endcase

    wr_rec.state   = st;
    wr_rec.mark    = mark;
    wr_rec.fwd_seq = sq[0];
    wr_rec.rev_seq = sq[1];

    res = '0;
    if (valid_hdr) begin
      res.conn_state    = st;
      res.timeout_secs  = tmo;
      res.payload_len   = plen;
      res.learned_mask  = learned;
      res.fwd_known     = mark[MK_KNOWN_FWD];
      res.rev_known     = mark[MK_KNOWN_FWD + 1];
      res.fwd_start_seq = sq[0];
      res.rev_start_seq = sq[1];
      res.seq_assured   = mark[MK_ASSURED];
    end else begin
      res.status = 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (out_xfer) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_res <= res;
    end
  end

  assign m_tdata = OUT_DATA_W'(out_res);

`ifndef ASSERT_OFF
  // A header taken in IDLE is always worked on in the next cycle.
  a_take_then_calc: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == S_CALC))
    else $error("header taken but no record update followed");

  // A new result only appears after a record update cycle.
  a_result_from_calc: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_CALC))
    else $error("result appeared without a record update");

  // The table is written only when a result is loaded.
  a_write_with_result: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_CALC) && (!m_tvalid || m_tready))
    else $error("record written without loading a result");

  // An invalid header gives a result that is zero apart from its status.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.status) |-> (m_tdata[OUT_DATA_W-1:1] == '0))
    else $error("invalid-header result carries non-zero fields");
`endif

endmodule

### tb/tcp_connection_tracker_test.sv
// Self-checking testbench for the TCP connection tracker.
`timescale 1ns / 1ps

// Segment headers go in on the slave stream. Every header is also run through a
// behavioural copy of the tracker kept here: its own record tables, its own copy of the
// timeout and port registers. The result that this copy works out is queued. Each result
// transfer on the master stream is compared field by field with the oldest queued entry.
//
// The run starts with a short directed list. Its rows cover:
// - every way a header can be invalid;
// - a full handshake with both start sequences learned, a retransmitted SYN and a
//   conflicting SYN+ACK;
// - the assuring ACK, data, both FINs and a SYN in a later state;
// - a RST that carries payload, the largest segment, and the flag byte with all bits set.
// Rows whose result is plain to see carry it typed in. The other rows are checked against
// the predictor.
//
// Four random phases follow, each with its own register setting: all zero, all ones and
// two random settings. Most of the traffic in these phases is whole connections: SYN,
// SYN+ACK, ACK, data and then a close. Their sequence numbers are right most of the time
// and wrong now and then. The rest is raw noise.
//
// A slot is only ever used without the new-entry mark once a valid header has written it,
// because the record tables hold no defined value before that. Both streams idle at random,
// with calm stretches in between, and registers are only written once every outstanding
// result has come back.
module tcp_connection_tracker_test;
  import tct_pkg::*;

  localparam int IDLE_LIMIT = 2000;  // cycles without any transfer before giving up
  localparam int SETTLE     = 8;     // cycles allowed for the pipeline to empty

  localparam logic [7:0] F_FIN   = 8'd1 << FL_FIN;
  localparam logic [7:0] F_SYN   = 8'd1 << FL_SYN;
  localparam logic [7:0] F_RST   = 8'd1 << FL_RST;
  localparam logic [7:0] F_ACK   = 8'd1 << FL_ACK;
  // PSH, URG, ECE and CWR: the tracker ignores these bits, so they are set at random.
  localparam logic [7:0] F_SPARE = 8'hE8;

  localparam logic HDR_OK  = 1'b0;
  localparam logic HDR_BAD = 1'b1;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  tcp_connection_tracker uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // The predictor's copy of the registers and of the connection records.
  logic [15:0] tmo_syn_sent, tmo_syn_recv, tmo_established, tmo_half_closed, tmo_closed;
  logic [15:0] tracked_port_cfg;
  logic [2:0]  state_tab [CONN_SLOTS];
  logic [7:0]  mark_tab  [CONN_SLOTS];
  logic [31:0] fwd_tab   [CONN_SLOTS];
  logic [31:0] rev_tab   [CONN_SLOTS];
  bit          slot_open [CONN_SLOTS];

  seg_result_t pending_results[$];
  int          mismatches = 0;
  int          seg_count = 0;
  int          tx_calm = 0;
  int          rx_calm = 0;
  int          rx_wait = 0;
  int          idle_cycles = 0;
  logic [CSLOT_W-1:0] active_slots [8];

  typedef struct {
    seg_hdr_t    h;
    bit          typed;
    seg_result_t want;
  } drow_t;

  drow_t plan[$];

  function automatic logic [15:0] timeout_for(input logic [2:0] st);
    case (st)
      CS_SYN_SENT:    return tmo_syn_sent;
      CS_SYN_RECV:    return tmo_syn_recv;
      CS_ESTABLISHED: return tmo_established;
      CS_HALF_CLOSED: return tmo_half_closed;
      CS_CLOSED:      return tmo_closed;
      default:        return 16'd0;
    endcase
  endfunction

  // Applies one header to the record tables and returns the result it should produce.
  function automatic seg_result_t track_segment(input seg_hdr_t h);
    seg_result_t       r;
    logic [15:0]       hlen, plen;
    logic [2:0]        st;
    logic [7:0]        mk;
    logic [1:0][31:0]  sq;
    logic [1:0]        learned;
    logic [CSLOT_W-1:0] slot;
    logic              d, rd;
    logic [2:0]        kd, kr, cd, cr, fd;
    r = '0;
    hlen = {10'd0, h.data_offset, 2'b00};
    if (h.segment_len < MIN_HDR_BYTES || hlen < MIN_HDR_BYTES || hlen > h.segment_len) begin
      r.status = HDR_BAD;
      return r;
    end
    plen = h.segment_len - hlen;
    if (h.tcp_flags[FL_SYN] && (plen != 0 || h.tcp_flags[FL_RST] || h.tcp_flags[FL_FIN])) begin
      r.status = HDR_BAD;
      return r;
    end
    if (h.tcp_flags[FL_RST]) plen = '0;
    slot = h.conn_slot;
    if (h.new_entry) begin
      st = CS_NEW;
      mk = '0;
      mk[MK_TRACKED] = (h.src_port == tracked_port_cfg) || (h.dst_port == tracked_port_cfg);
      sq = '0;
    end else begin
      st = state_tab[slot];
      mk = mark_tab[slot];
      sq[0] = fwd_tab[slot];
      sq[1] = rev_tab[slot];
    end
    d  = h.direction;
    rd = ~h.direction;
    kd = 3'(MK_KNOWN_FWD) + {2'b00, d};
    kr = 3'(MK_KNOWN_FWD) + {2'b00, rd};
    cd = 3'(MK_CLIENT_FWD) + {2'b00, d};
    cr = 3'(MK_CLIENT_FWD) + {2'b00, rd};
    fd = 3'(MK_FIN_FWD) + {2'b00, d};
    learned = '0;
    // Start sequences are learned only on the tracked port; a SYN never overwrites a sequence
    // already known in a direction with a different one, but the assuring ACK may.
    if (mk[MK_TRACKED]) begin
      if (h.tcp_flags[FL_SYN]) begin
        if (!(mk[kd] && sq[d] != h.seq_num + 32'd1)) begin
          sq[d] = h.seq_num + 32'd1;
          mk[kd] = 1'b1;
          learned[d] = 1'b1;
        end
        if (h.tcp_flags[FL_ACK]) begin
          if (!(mk[kr] && sq[rd] != h.ack_num)) begin
            sq[rd] = h.ack_num;
            mk[kr] = 1'b1;
            learned[rd] = 1'b1;
          end
          mk[cr] = 1'b1;
        end else begin
          mk[cd] = 1'b1;
        end
      end else if (!mk[MK_ASSURED] && h.tcp_flags[FL_ACK] && sq[d] == h.seq_num &&
                   plen == 0 && mk[kd] && mk[cd]) begin
        sq[rd] = h.ack_num;
        mk[kr] = 1'b1;
        mk[MK_ASSURED] = 1'b1;
        learned[rd] = 1'b1;
      end
    end
    // SYN takes precedence over FIN, and FIN over RST.
    if (h.tcp_flags[FL_SYN]) begin
      if (h.tcp_flags[FL_ACK]) begin
        if (st <= CS_SYN_SENT) st = CS_SYN_RECV;
      end else if (st == CS_NEW) begin
        st = CS_SYN_SENT;
      end
    end else if (h.tcp_flags[FL_FIN]) begin
      mk[fd] = 1'b1;
      st = (mk[MK_FIN_FWD +: 2] == 2'b11) ? CS_CLOSED : CS_HALF_CLOSED;
    end else if (h.tcp_flags[FL_RST]) begin
      st = CS_CLOSED;
    end else if (st < CS_ESTABLISHED) begin
      st = CS_ESTABLISHED;
    end
    state_tab[slot] = st;
    mark_tab[slot]  = mk;
    fwd_tab[slot]   = sq[0];
    rev_tab[slot]   = sq[1];
    slot_open[slot] = 1'b1;
    r.status        = HDR_OK;
    r.conn_state    = st;
    r.timeout_secs  = timeout_for(st);
    r.payload_len   = plen;
    r.learned_mask  = learned;
    r.fwd_known     = mk[MK_KNOWN_FWD];
    r.rev_known     = mk[MK_KNOWN_FWD + 1];
    r.fwd_start_seq = sq[0];
    r.rev_start_seq = sq[1];
    r.seq_assured   = mk[MK_ASSURED];
    return r;
  endfunction

  function automatic seg_hdr_t hdr(input logic [CSLOT_W-1:0] slot, input bit newe,
      input bit dir, input logic [3:0] off, input logic [15:0] len,
      input logic [7:0] flags, input logic [31:0] seq, input logic [31:0] ack,
      input logic [15:0] sp, input logic [15:0] dp);
    seg_hdr_t h;
    h.conn_slot   = slot;
    h.new_entry   = newe;
    h.direction   = dir;
    h.data_offset = off;
    h.segment_len = len;
    h.tcp_flags   = flags;
    h.seq_num     = seq;
    h.ack_num     = ack;
    h.src_port    = sp;
    h.dst_port    = dp;
    return h;
  endfunction

  // A well-formed header with a random header length and the payload asked for.
  function automatic seg_hdr_t pkt(input logic [CSLOT_W-1:0] slot, input bit newe,
      input bit dir, input logic [7:0] flags, input logic [31:0] seq,
      input logic [31:0] ack, input logic [15:0] plen, input logic [15:0] sp,
      input logic [15:0] dp);
    logic [3:0]  off;
    logic [15:0] hlen;
    off = 4'($urandom_range(5, 15));
    hlen = {10'd0, off, 2'b00};
    if (plen > 16'hFFFF - hlen) plen = 16'hFFFF - hlen;
    return hdr(slot, newe, dir, off, hlen + plen, flags, seq, ack, sp, dp);
  endfunction

  function automatic seg_result_t verdict(input logic status, input logic [2:0] st,
      input logic [15:0] tmo, input logic [15:0] plen);
    seg_result_t r;
    r = '0;
    r.status       = status;
    r.conn_state   = st;
    r.timeout_secs = tmo;
    r.payload_len  = plen;
    return r;
  endfunction

  function automatic logic [7:0] extra();
    return 8'($urandom) & F_SPARE;
  endfunction

  function automatic logic [15:0] draw_payload();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 16'd0;
      9:             return 16'($urandom);
      default:       return 16'($urandom_range(1, 1460));
    endcase
  endfunction

  // Gap before the next header, with occasional calm stretches of back-to-back transfers.
  function automatic int draw_gap();
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      tx_calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
      input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
      input logic [31:0] got);
    if (got !== want) note_mismatch(what, want, got);
  endtask

  // Predicts, queues the expected result (the typed-in one where given) and sends.
  task automatic feed(input seg_hdr_t h, input bit typed = 1'b0,
      input seg_result_t want = '0);
    seg_result_t p;
    int gap;
    p = track_segment(h);
    pending_results.push_back(typed ? want : p);
    seg_count++;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= h;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Holds the sender back until every expected result has arrived and the block has settled.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] ss, input logic [15:0] sr,
      input logic [15:0] es, input logic [15:0] hc, input logic [15:0] cl,
      input logic [15:0] port);
    logic [CFG_IDX_W-1:0] idx [6];
    logic [15:0]          vals [6];
    idx  = '{REG_SYN_SENT_TIMEOUT, REG_SYN_RECV_TIMEOUT, REG_ESTABLISHED_TIMEOUT,
             REG_HALF_CLOSED_TIMEOUT, REG_CLOSED_TIMEOUT, REG_TRACKED_PORT};
    vals = '{ss, sr, es, hc, cl, port};
    for (int k = 0; k < 6; k++) begin
      cfg_index <= idx[k];
      cfg_data  <= vals[k];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[k])
        REG_SYN_SENT_TIMEOUT:    tmo_syn_sent     = vals[k];
        REG_SYN_RECV_TIMEOUT:    tmo_syn_recv     = vals[k];
        REG_ESTABLISHED_TIMEOUT: tmo_established  = vals[k];
        REG_HALF_CLOSED_TIMEOUT: tmo_half_closed  = vals[k];
        REG_CLOSED_TIMEOUT:      tmo_closed       = vals[k];
        REG_TRACKED_PORT:        tracked_port_cfg = vals[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // One connection on a slot: handshake, some data and a close, with occasional faults.
  task automatic run_flow(input logic [CSLOT_W-1:0] slot);
    bit          d, rd, side;
    logic [15:0] cp, svp;
    logic [31:0] cs, ss;
    logic [7:0]  fl;
    d   = 1'($urandom);
    rd  = ~d;
    cp  = 16'($urandom);
    svp = ($urandom_range(0, 4) == 0) ? 16'($urandom) : tracked_port_cfg;
    cs  = $urandom;
    ss  = $urandom;
    feed(pkt(slot, 1'b1, d, F_SYN | extra(), cs, $urandom, 16'd0, cp, svp));
    // A retransmitted SYN, half of them with a conflicting sequence.
    if ($urandom_range(0, 4) == 0)
      feed(pkt(slot, 1'b0, d, F_SYN | extra(), $urandom_range(0, 1) ? cs : $urandom,
               $urandom, 16'd0, cp, svp));
    feed(pkt(slot, 1'b0, rd, F_SYN | F_ACK | extra(), ss,
             ($urandom_range(0, 7) == 0) ? $urandom : cs + 32'd1, 16'd0, svp, cp));
    feed(pkt(slot, 1'b0, d, F_ACK | extra(),
             ($urandom_range(0, 7) == 0) ? $urandom : cs + 32'd1, ss + 32'd1,
             ($urandom_range(0, 7) == 0) ? draw_payload() : 16'd0, cp, svp));
    repeat ($urandom_range(0, 6)) begin
      side = 1'($urandom);
      fl = (($urandom_range(0, 7) == 0) ? 8'h00 : F_ACK) | extra();
      feed(pkt(slot, 1'b0, side ? rd : d, fl, $urandom, $urandom, draw_payload(),
               side ? svp : cp, side ? cp : svp));
    end
    side = 1'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        feed(pkt(slot, 1'b0, side ? rd : d, F_FIN | F_ACK | extra(), $urandom, $urandom,
                 draw_payload(), side ? svp : cp, side ? cp : svp));
        feed(pkt(slot, 1'b0, side ? d : rd, F_FIN | F_ACK | extra(), $urandom, $urandom,
                 draw_payload(), side ? cp : svp, side ? svp : cp));
      end
      1: feed(pkt(slot, 1'b0, side ? rd : d, F_FIN | extra(), $urandom, $urandom,
                  draw_payload(), side ? svp : cp, side ? cp : svp));
      2: feed(pkt(slot, 1'b0, side ? rd : d, F_RST | (F_ACK & 8'($urandom)) | extra(),
                  $urandom, $urandom, draw_payload(), side ? svp : cp, side ? cp : svp));
      default: ;
    endcase
  endtask

  // Raw random header; half of them get a plausible length so they can pass the header check.
  task automatic feed_noise();
    logic [159:0] raw;
    seg_hdr_t     h;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    h = raw[IN_DATA_W-1:0];
    if ($urandom_range(0, 1)) begin
      h.data_offset = 4'($urandom_range(5, 15));
      h.segment_len = {10'd0, h.data_offset, 2'b00} + 16'($urandom_range(0, 3));
    end
    if ($urandom_range(0, 1)) h.conn_slot = active_slots[3'($urandom_range(0, 7))];
    // A slot that no valid header has written yet must be opened first.
    if (!slot_open[h.conn_slot]) h.new_entry = 1'b1;
    feed(h);
  endtask

  task automatic random_phase(input int items, input bit pause_midway);
    int         first;
    logic [2:0] k;
    first = seg_count;
    while (seg_count - first < items) begin
      if (pause_midway && seg_count - first >= items / 2) begin
        pause_midway = 1'b0;
        drain();
      end
      if ($urandom_range(0, 4) == 0) begin
        feed_noise();
      end else begin
        k = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 5) == 0) active_slots[k] = CSLOT_W'($urandom);
        run_flow(active_slots[k]);
      end
    end
  endtask

  // Result side: random stalls per transfer, and every result is checked as it arrives.
  always @(posedge clk) begin : result_side
    seg_result_t got, want;
    int          stall;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else if (m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing outstanding", '0, {29'd0, got.conn_state});
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("conn_state", 32'(want.conn_state), 32'(got.conn_state));
        check_field("timeout_secs", 32'(want.timeout_secs), 32'(got.timeout_secs));
        check_field("payload_len", 32'(want.payload_len), 32'(got.payload_len));
        check_field("learned_mask", 32'(want.learned_mask), 32'(got.learned_mask));
        check_field("fwd_known", 32'(want.fwd_known), 32'(got.fwd_known));
        check_field("rev_known", 32'(want.rev_known), 32'(got.rev_known));
        check_field("fwd_start_seq", want.fwd_start_seq, got.fwd_start_seq);
        check_field("rev_start_seq", want.rev_start_seq, got.rev_start_seq);
        check_field("seq_assured", 32'(want.seq_assured), 32'(got.seq_assured));
      end
      if (rx_calm > 0) begin
        rx_calm <= rx_calm - 1;
        stall = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        rx_calm <= $urandom_range(20, 60);
        stall = 0;
      end else begin
        stall = $urandom_range(0, 12);
      end
      rx_wait  <= stall;
      m_tready <= (stall == 0);
    end else if (!m_tready) begin
      if (rx_wait <= 1) m_tready <= 1'b1;
      rx_wait <= rx_wait - 1;
    end
  end

  // Watchdog: a long stretch with no transfer on any channel means the block has hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SYN_SENT_TIMEOUT;
    cfg_data  = '0;
    tmo_syn_sent     = 16'd180;
    tmo_syn_recv     = 16'd60;
    tmo_established  = 16'd7200;
    tmo_half_closed  = 16'd120;
    tmo_closed       = 16'd30;
    tracked_port_cfg = 16'd80;
    foreach (slot_open[i]) slot_open[i] = 1'b0;
    foreach (active_slots[i]) active_slots[i] = CSLOT_W'($urandom);

    // Invalid headers: too short, header too short or too long, SYN with payload,
    // and SYN together with RST or FIN.
    plan.push_back('{hdr(10'd1023, 1, 0, 4'd0, 16'd0, 8'h00, 0, 0, 0, 0), 1,
                     verdict(HDR_BAD, CS_NEW, 0, 0)});
    plan.push_back('{hdr(10'd1023, 1, 1, 4'd5, 16'd19, F_ACK, 1, 1, 80, 80), 1,
                     verdict(HDR_BAD, CS_NEW, 0, 0)});
    plan.push_back('{hdr(10'd7, 1, 0, 4'd4, 16'd100, F_ACK, 2, 2, 80, 81), 1,
                     verdict(HDR_BAD, CS_NEW, 0, 0)});
    plan.push_back('{hdr(10'd7, 1, 0, 4'd15, 16'd59, F_ACK, 3, 3, 81, 80), 1,
                     verdict(HDR_BAD, CS_NEW, 0, 0)});
    plan.push_back('{hdr(10'd7, 1, 0, 4'd5, 16'd21, F_SYN, 4, 4, 1, 80), 1,
                     verdict(HDR_BAD, CS_NEW, 0, 0)});
    plan.push_back('{hdr(10'd7, 1, 0, 4'd5, 16'd20, F_SYN | F_RST, 5, 5, 1, 80), 1,
                     verdict(HDR_BAD, CS_NEW, 0, 0)});
    plan.push_back('{hdr(10'd7, 1, 1, 4'd5, 16'd20, F_SYN | F_FIN, 6, 6, 80, 1), 1,
                     verdict(HDR_BAD, CS_NEW, 0, 0)});
    // A tracked connection from start to finish; the client sequence wraps to zero.
    plan.push_back('{hdr(10'd0, 1, 0, 4'd5, 16'd20, F_SYN, 32'hFFFF_FFFF, 0,
                         16'd40000, 16'd80), 0, '0});
    plan.push_back('{hdr(10'd0, 0, 0, 4'd6, 16'd24, F_SYN, 32'hFFFF_FFFF, 0,
                         16'd40000, 16'd80), 0, '0});
    plan.push_back('{hdr(10'd0, 0, 1, 4'd5, 16'd20, F_SYN | F_ACK, 32'h1000, 0,
                         16'd80, 16'd40000), 0, '0});
    // SYN+ACK whose sequence conflicts with the one already learned.
    plan.push_back('{hdr(10'd0, 0, 1, 4'd5, 16'd20, F_SYN | F_ACK, 32'h2000, 0,
                         16'd80, 16'd40000), 0, '0});
    plan.push_back('{hdr(10'd0, 0, 0, 4'd5, 16'd20, F_ACK, 0, 32'h1001,
                         16'd40000, 16'd80), 0, '0});
    plan.push_back('{hdr(10'd0, 0, 1, 4'd8, 16'd1492, F_ACK | 8'h08, 32'h1001, 1,
                         16'd80, 16'd40000), 0, '0});
    plan.push_back('{hdr(10'd0, 0, 0, 4'd5, 16'd20, F_FIN | F_ACK, 1, 32'h15B5,
                         16'd40000, 16'd80), 0, '0});
    plan.push_back('{hdr(10'd0, 0, 1, 4'd5, 16'd20, F_FIN | F_ACK, 32'h15B5, 2,
                         16'd80, 16'd40000), 0, '0});
    // SYN on a closed connection leaves the state alone.
    plan.push_back('{hdr(10'd0, 0, 0, 4'd5, 16'd20, F_SYN, 32'hFFFF_FFFF, 0,
                         16'd40000, 16'd80), 0, '0});
    // RST with payload on an untracked connection: payload reported as zero.
    plan.push_back('{hdr(10'd1023, 1, 1, 4'd5, 16'd300, F_RST, 9, 9, 16'd1234, 16'd5678),
                     1, verdict(HDR_OK, CS_CLOSED, 16'd30, 16'd0)});
    // Largest segment with the longest header.
    plan.push_back('{hdr(10'd5, 1, 0, 4'd15, 16'hFFFF, F_ACK, 0, 0, 16'd1, 16'd2),
                     1, verdict(HDR_OK, CS_ESTABLISHED, 16'd7200, 16'd65475)});
    plan.push_back('{hdr(10'd5, 0, 0, 4'd5, 16'd20, F_SYN | F_ACK, 0, 0, 16'd1, 16'd2),
                     0, '0});
    plan.push_back('{hdr(10'd5, 1, 1, 4'd5, 16'd20, F_SYN | F_ACK | F_SPARE,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd80, 16'hFFFF), 0, '0});
    plan.push_back('{hdr(10'd5, 0, 1, 4'd5, 16'd20, 8'hFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF), 1,
                     verdict(HDR_BAD, CS_NEW, 0, 0)});
    plan.push_back('{hdr(10'd5, 0, 1, 4'd5, 16'd20, F_FIN, 7, 7, 16'd80, 16'hFFFF),
                     0, '0});
    // FIN beats RST when both are set; the second FIN closes the connection.
    plan.push_back('{hdr(10'd5, 0, 0, 4'd5, 16'd30, 8'hFF & ~F_SYN, 8, 8,
                         16'hFFFF, 16'd80), 0, '0});
    plan.push_back('{hdr(10'd1023, 0, 0, 4'd5, 16'd20, 8'h00, 0, 0, 16'd5678, 16'd1234),
                     0, '0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) feed(plan[i].h, plan[i].typed, plan[i].want);
    drain();

    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_phase(400, 1'b0);
    drain();
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(400, 1'b0);
    drain();
    program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
    random_phase(600, 1'b1);
    drain();
    program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom_range(0, 1023)));
    random_phase(600, 1'b0);
    drain();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
